// ===== sv/odo_pkg.sv =====
// Shared types, constants and functions for the differential drive odometry block.
package odo_pkg;

  localparam int unsigned CordicItersDef = 16;
  localparam int unsigned CordicItersMax = 24;
  localparam int unsigned IdxW = 5;
  localparam int unsigned DivSteps = 29;            // two quotient bits per step, 58 bits

  localparam logic [15:0] MmPerStepRst = 16'd8454;
  localparam logic [15:0] WheelBaseRst = 16'd13440;
  localparam logic [29:0] InvTwoPiQ32 = 30'd683565276;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  localparam logic [0:0] RegMmPerStep = 1'b0;
  localparam logic [0:0] RegWheelBase = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_L,
    OP_MUL_R,
    OP_DIV_INIT,
    OP_DIV,
    OP_PM0,
    OP_PM1,
    OP_COR_INIT,
    OP_COR,
    OP_MX,
    OP_MY,
    OP_COMMIT
  } odo_op_e;

  typedef struct packed {
    odo_op_e         op;
    logic [IdxW-1:0] idx;
  } odo_cmd_t;

  typedef struct packed {
    logic out_free;
  } odo_sts_t;

  function automatic logic [31:0] atan_bam(input logic [IdxW-1:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    begin
      if (v > 50'sd2147483647) r = 32'sh7fffffff;
      else if (v < -50'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage

// ===== sv/odo_ctrl.sv =====
// Sequencer that steps the odometry datapath through one sample.
module odo_ctrl #(
  parameter int unsigned CORDIC_ITERS = odo_pkg::CordicItersDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  odo_pkg::odo_sts_t sts_i,
  output odo_pkg::odo_cmd_t cmd_o
);
  import odo_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_L    = 4'd1;
  localparam logic [3:0] S_MUL_R    = 4'd2;
  localparam logic [3:0] S_DIV_INIT = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_PM0      = 4'd5;
  localparam logic [3:0] S_PM1      = 4'd6;
  localparam logic [3:0] S_COR_INIT = 4'd7;
  localparam logic [3:0] S_COR      = 4'd8;
  localparam logic [3:0] S_MX       = 4'd9;
  localparam logic [3:0] S_MY       = 4'd10;
  localparam logic [3:0] S_COMMIT   = 4'd11;

  localparam logic [IdxW-1:0] DivLast = IdxW'(DivSteps - 1);
  localparam logic [IdxW-1:0] CorLast = IdxW'(CORDIC_ITERS - 1);

  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_MUL_L;
        end
      end
      S_MUL_L: begin
        cmd_o.op = OP_MUL_L;
        state_d  = S_MUL_R;
      end
      S_MUL_R: begin
        cmd_o.op = OP_MUL_R;
        state_d  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DivLast) state_d = S_PM0;
      end
      S_PM0: begin
        cmd_o.op = OP_PM0;
        state_d  = S_PM1;
      end
      S_PM1: begin
        cmd_o.op = OP_PM1;
        state_d  = S_COR_INIT;
      end
      S_COR_INIT: begin
        cmd_o.op = OP_COR_INIT;
        cnt_d    = '0;
        state_d  = S_COR;
      end
      S_COR: begin
        cmd_o.op = OP_COR;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CorLast) state_d = S_MX;
      end
      S_MX: begin
        cmd_o.op = OP_MX;
        state_d  = S_MY;
      end
      S_MY: begin
        cmd_o.op = OP_MY;
        state_d  = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.op = OP_COMMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== sv/odo_dp.sv =====
// Datapath: travels, heading divider, angle multiply, CORDIC and pose update.
module odo_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  odo_pkg::odo_cmd_t   cmd_i,
  output odo_pkg::odo_sts_t   sts_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_addr_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [31:0]         left_count_i,
  input  logic [31:0]         right_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic [15:0]         heading_o,
  output logic signed [31:0]  moved_distance_o
);
  import odo_pkg::*;

  logic [15:0]        mm_q, wb_q;
  logic [31:0]        last_l_q, last_r_q, in_l_q, in_r_q;
  logic signed [31:0] cur_x_q, cur_y_q, dist_q;
  logic [15:0]        cur_h_q;
  logic signed [48:0] dl_q, dr_q;
  logic               neg_q;
  logic [57:0]        quo_q;
  logic [15:0]        rem_q;
  logic [48:0]        p_q;
  logic               flip_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic signed [64:0] prod_q;
  logic               out_valid_q;
  logic signed [31:0] ox_q, oy_q, od_q;
  logic [15:0]        oh_q;

  // travel of one wheel
  logic [31:0]        delta;
  logic signed [48:0] travel;
  always_comb begin
    delta  = (cmd_i.op == OP_MUL_L) ? in_l_q - last_l_q : in_r_q - last_r_q;
    travel = 49'($signed(delta)) * 49'($signed({1'b0, mm_q}));
  end

  logic signed [49:0] sum, diff;
  logic signed [57:0] num;
  logic [57:0]        mag;
  logic [16:0]        wb_eff;
  always_comb begin
    sum    = 50'(dl_q) + 50'(dr_q);
    diff   = 50'(dr_q) - 50'(dl_q);
    num    = 58'(diff) <<< 8;
    mag    = num[57] ? 58'(-num) : 58'(num);
    wb_eff = (wb_q == '0) ? 17'd1 : {1'b0, wb_q};
  end

  // two restoring division steps
  logic [16:0] r1, r2, r1s, r2s;
  logic        b1, b2;
  always_comb begin
    r1  = {rem_q, quo_q[57]};
    b1  = (r1 >= wb_eff);
    r1s = b1 ? r1 - wb_eff : r1;
    r2  = {r1s[15:0], quo_q[56]};
    b2  = (r2 >= wb_eff);
    r2s = b2 ? r2 - wb_eff : r2;
  end

  logic [57:0] tq;
  logic [48:0] t49;
  logic [53:0] pp0;
  logic [54:0] pp1;
  always_comb begin
    tq  = neg_q ? -quo_q : quo_q;
    t49 = tq[48:0];
    pp0 = t49[23:0] * InvTwoPiQ32;
    pp1 = t49[48:24] * InvTwoPiQ32;
  end

  logic [31:0] ang, ang_f;
  logic        flip;
  always_comb begin
    ang   = {cur_h_q, 16'd0} + p_q[48:17];
    flip  = ang[31] ^ ang[30];
    ang_f = flip ? {~ang[31], ang[30:0]} : ang;
  end

  logic signed [33:0] xs, ys, at;
  always_comb begin
    xs = cx_q >>> cmd_i.idx;
    ys = cy_q >>> cmd_i.idx;
    at = $signed({2'b00, atan_bam(cmd_i.idx)});
  end

  logic signed [33:0] c_f, s_f, mop;
  logic signed [64:0] mul;
  logic signed [49:0] upd;
  always_comb begin
    c_f = flip_q ? -cx_q : cx_q;
    s_f = flip_q ? -cy_q : cy_q;
    mop = (cmd_i.op == OP_MX) ? c_f : s_f;
    mul = 65'(dist_q) * 65'(mop);
    upd = 50'(prod_q >>> 30) +
          50'((cmd_i.op == OP_MY) ? cur_x_q : cur_y_q);
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_q        <= MmPerStepRst;
      wb_q        <= WheelBaseRst;
      last_l_q    <= '0;
      last_r_q    <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_h_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegMmPerStep: mm_q <= cfg_data_i;
          RegWheelBase: wb_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_MY: cur_x_q <= sat32(upd);
        OP_COMMIT: begin
          cur_y_q     <= sat32(upd);
          cur_h_q     <= cur_h_q + p_q[47:32];
          last_l_q    <= in_l_q;
          last_r_q    <= in_r_q;
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        in_l_q <= left_count_i;
        in_r_q <= right_count_i;
      end
      OP_MUL_L: dl_q <= travel;
      OP_MUL_R: dr_q <= travel;
      OP_DIV_INIT: begin
        dist_q <= sat32(sum >>> 1);
        neg_q  <= num[57];
        quo_q  <= mag;
        rem_q  <= '0;
      end
      OP_DIV: begin
        rem_q <= r2s[15:0];
        quo_q <= {quo_q[55:0], b1, b2};
      end
      OP_PM0: p_q <= pp0[48:0];
      OP_PM1: p_q <= p_q + {pp1[24:0], 24'd0};
      OP_COR_INIT: begin
        flip_q <= flip;
        cx_q   <= CordicGain;
        cy_q   <= '0;
        cz_q   <= 34'($signed(ang_f));
      end
      OP_COR: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end
      end
      OP_MX: prod_q <= mul;
      OP_MY: prod_q <= mul;
      OP_COMMIT: begin
        ox_q <= cur_x_q;
        oy_q <= sat32(upd);
        oh_q <= cur_h_q + p_q[47:32];
        od_q <= dist_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign pos_x_o          = ox_q;
  assign pos_y_o          = oy_q;
  assign heading_o        = oh_q;
  assign moved_distance_o = od_q;

endmodule

// ===== sv/differential_drive_odometry.sv =====
// Differential drive odometry: one encoder sample in, one updated pose out. Each sample
// passes through two travel multiplies, a 29-step radix-4 divider by the wheel base, two
// partial products for the angle scaling, one CORDIC iteration per cycle and two pose
// multiplies. The next sample is taken once the sequencer is back at rest; the result
// waits in an output register meanwhile.
module differential_drive_odometry #(
  parameter int unsigned CORDIC_ITERS = odo_pkg::CordicItersDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_addr_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // left_count[31:0], right_count[63:32]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata    // pos_x, pos_y, heading[79:64], moved_distance
);
  import odo_pkg::*;

  odo_cmd_t cmd;
  odo_sts_t sts;
  logic signed [31:0] px, py, md;
  logic [15:0] hd;

  odo_ctrl #(.CORDIC_ITERS(CORDIC_ITERS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  odo_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .left_count_i     (s_axis_tdata[31:0]),
    .right_count_i    (s_axis_tdata[63:32]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .pos_x_o          (px),
    .pos_y_o          (py),
    .heading_o        (hd),
    .moved_distance_o (md)
  );

  assign m_axis_tdata = {md, hd, py, px};

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a sample is in work");
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared without computation");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the differential drive odometry block.
`timescale 1ns / 1ps

module testbench;
  import odo_pkg::*;

  typedef struct packed {
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] moved_distance;
    logic [15:0]        heading;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } pose_t;

  typedef struct {
    bit      is_cfg;
    logic    addr;
    logic [15:0] data;
    sample_t smp;
  } job_t;

  localparam int unsigned Iters = CordicItersDef;
  localparam longint CycleLimit = 2000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_addr_i = '0;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;

  differential_drive_odometry i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0]        prd_mm, prd_wb, prd_head;
  logic [31:0]        prd_last_l, prd_last_r;
  logic signed [31:0] prd_x, prd_y;

  job_t  pending_jobs[$];
  pose_t pose_queue[$];
  int    errors = 0;
  longint cycle = 0;
  bit    stim_done = 0;
  bit    quiet_tx = 0, quiet_rx = 0;
  int    hold_off = 0;
  bit    cfg_go;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    bit flip;
    longint x, y, z, xs, ys;
    logic [31:0] a;
    flip = ang[31] ^ ang[30];
    a = flip ? ang - 32'h8000_0000 : ang;
    x = longint'(CordicGain);
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < Iters; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_bam(i[IdxW-1:0]));
      end else begin
        x += ys; y -= xs; z += longint'(atan_bam(i[IdxW-1:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic pose_t advance_pose(sample_t smp);
    longint dl, dr, mean_travel, wb, t, c, s;
    logic [63:0] p;
    logic [31:0] half;
    pose_t r;
    dl = longint'($signed(smp.left_count - prd_last_l)) * longint'({1'b0, prd_mm});
    dr = longint'($signed(smp.right_count - prd_last_r)) * longint'({1'b0, prd_mm});
    mean_travel = clip32(floor_shr(dl + dr, 1));
    wb = (prd_wb == 0) ? 1 : longint'({1'b0, prd_wb});
    t = ((dr - dl) * 256) / wb;
    p = 64'(t) * 64'd683565276;
    half = p[48:17];
    rotate_unit({prd_head, 16'd0} + half, c, s);
    prd_x = 32'(clip32(longint'(prd_x) + floor_shr(mean_travel * c, 30)));
    prd_y = 32'(clip32(longint'(prd_y) + floor_shr(mean_travel * s, 30)));
    prd_head = prd_head + p[47:32];
    prd_last_l = smp.left_count;
    prd_last_r = smp.right_count;
    r.pos_x = prd_x;
    r.pos_y = prd_y;
    r.heading = prd_head;
    r.moved_distance = 32'(mean_travel);
    return r;
  endfunction

  function automatic logic [31:0] prd_last_sum(int pick);
    return pick ? 32'h7fff_ffff : 32'h8000_0000;
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return prd_last_sum($urandom_range(0, 1));
      default: return 32'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // random walk of counts so that most samples are small realistic steps
  logic [31:0] walk_l = 0, walk_r = 0;

  task automatic push_sample(logic [31:0] l, logic [31:0] r);
    job_t j;
    j.is_cfg = 0; j.addr = 0; j.data = 0;
    j.smp.left_count = l;
    j.smp.right_count = r;
    pending_jobs.push_back(j);
  endtask

  task automatic push_cfg(logic a, logic [15:0] d);
    job_t j;
    j.is_cfg = 1; j.addr = a; j.data = d; j.smp = '0;
    pending_jobs.push_back(j);
  endtask

  task automatic push_walk(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        walk_l = $urandom(); walk_r = $urandom();
      end else begin
        walk_l += 32'($signed($urandom_range(0, 600)) - 200);
        walk_r += 32'($signed($urandom_range(0, 600)) - 200);
      end
      push_sample(walk_l, walk_r);
    end
  endtask

  initial begin
    // directed part, first at the reset configuration, then with register writes
    push_sample(32'd0, 32'd0);
    push_sample(32'd100, 32'd100);
    push_sample(32'd100, 32'd300);
    push_sample(32'd500, 32'd100);
    push_sample(32'h7fff_ffff, 32'h8000_0000);
    push_sample(32'h8000_0000, 32'h7fff_ffff);
    push_sample(32'hffff_ffff, 32'hffff_ffff);
    push_sample(32'h0000_0000, 32'hffff_ffff);
    push_sample(32'h5555_5555, 32'haaaa_aaaa);
    push_sample(32'haaaa_aaaa, 32'h5555_5555);
    push_cfg(RegMmPerStep, 16'hffff);
    push_cfg(RegWheelBase, 16'd256);
    push_sample(32'd0, 32'd1000);
    push_sample(32'd2000, 32'd0);
    push_sample(32'h4000_0000, 32'hc000_0000);
    push_cfg(RegWheelBase, 16'd0);
    push_sample(32'd10, 32'd50);
    push_cfg(RegMmPerStep, 16'd0);
    push_sample(32'h1234_5678, 32'h8765_4321);
    push_cfg(RegMmPerStep, 16'd1);
    push_cfg(RegWheelBase, 16'hffff);
    push_sample(32'd0, 32'd0);
    push_sample(32'h7fff_ffff, 32'h0000_0001);
    walk_l = 0; walk_r = 0;
    for (int ph = 0; ph < 6; ph++) begin
      push_cfg(RegMmPerStep, ph == 0 ? 16'd8454 : 16'($urandom_range(1, 65535)));
      push_cfg(RegWheelBase, ph == 0 ? 16'd13440 : 16'($urandom_range(256, 65535)));
      for (int k = 0; k < 250; k++) begin
        if ($urandom_range(0, 9) == 0) push_sample(rand_count(), rand_count());
        else push_walk(1);
      end
    end
  end

  // sender: samples and register writes, writes only once the block has drained
  int drain = 0;
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    quiet_tx <= (cycle > 4000 && cycle < 40000);
    cfg_go = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pose_queue.push_back(advance_pose(sample_t'(s_axis_tdata)));
        void'(pending_jobs.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_jobs.size() == 0 || (s_axis_tvalid && s_axis_tready &&
            pending_jobs.size() == 0)) begin
          s_axis_tvalid <= 1'b0;
          if (pending_jobs.size() == 0) stim_done <= 1;
        end else if (pending_jobs[0].is_cfg) begin
          s_axis_tvalid <= 1'b0;
          if (!s_axis_tvalid && pose_queue.size() == 0) begin
            if (drain < 100) drain <= drain + 1;
            else begin
              drain <= 0;
              cfg_go = 1'b1;
              cfg_addr_i <= pending_jobs[0].addr;
              cfg_data_i <= pending_jobs[0].data;
              if (pending_jobs[0].addr == RegMmPerStep) prd_mm <= pending_jobs[0].data;
              else prd_wb <= pending_jobs[0].data;
              void'(pending_jobs.pop_front());
            end
          end
        end else if (!quiet_tx && $urandom_range(0, 99) < 24) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_jobs[0].smp;
        end
      end
    end
    cfg_we_i <= cfg_go;
  end

  // receiver: random stalls, one long hold-off, then a stretch without stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cycle == 3000) hold_off <= 3000;
      else if (hold_off > 0) hold_off <= hold_off - 1;
      quiet_rx <= (cycle > 4000 && cycle < 40000);
      if (hold_off > 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= quiet_rx || ($urandom_range(0, 99) >= 24);
      if (m_axis_tvalid && m_axis_tready) begin
        pose_t got, want;
        got = pose_t'(m_axis_tdata);
        if (pose_queue.size() == 0) begin
          $error("unexpected pose transfer %h", m_axis_tdata);
          errors = errors + 1;
        end else begin
          want = pose_queue.pop_front();
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
            errors = errors + 1;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
            errors = errors + 1;
          end
          if (got.heading !== want.heading) begin
            $error("heading: expected %0d, got %0d", want.heading, got.heading);
            errors = errors + 1;
          end
          if (got.moved_distance !== want.moved_distance) begin
            $error("moved_distance: expected %0d, got %0d", want.moved_distance,
                   got.moved_distance);
            errors = errors + 1;
          end
        end
      end
    end
  end

  initial begin
    prd_mm = MmPerStepRst;
    prd_wb = WheelBaseRst;
    prd_head = '0;
    prd_last_l = '0;
    prd_last_r = '0;
    prd_x = '0;
    prd_y = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stim_done && pose_queue.size() == 0) && cycle < CycleLimit)
      @(posedge clk_i);
    if (cycle >= CycleLimit) begin
      $display("[differential_drive_odometry] ERROR");
      $finish;
    end else begin
      repeat (200) @(posedge clk_i);
      if (errors == 0 && pose_queue.size() == 0) $display("[differential_drive_odometry] OK");
      else $display("[differential_drive_odometry] ERROR");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/odo_pkg.sv
sv/odo_ctrl.sv
sv/odo_dp.sv
sv/differential_drive_odometry.sv
test/testbench.sv
